[sv/touch_position_dead_band_macros.svh]
// ----------------------------------------------------------------------------
// touch position dead band: assertion macros
// shared concurrent check forms, clocked on the rising edge, reset masked
// ----------------------------------------------------------------------------
`ifndef TOUCH_POSITION_DEAD_BAND_MACROS_SVH
`define TOUCH_POSITION_DEAD_BAND_MACROS_SVH

// same-cycle implication
`define TPDB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPDB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tpdb_pkg.sv]
// ----------------------------------------------------------------------------
// tpdb_pkg
// shared types and constants of the touch position dead band block
// ----------------------------------------------------------------------------
package tpdb_pkg;

    // coordinate and register widths
    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 12;

    // configuration register indexes
    localparam logic CFG_X_LIMIT = 1'b0;
    localparam logic CFG_Y_LIMIT = 1'b1;

    // configuration reset values
    localparam logic [CFG_BITS-1:0] X_LIMIT_RST = 12'd240;
    localparam logic [CFG_BITS-1:0] Y_LIMIT_RST = 12'd320;

    // calibration constants
    localparam logic [11:0] Y_OFFSET     = 12'd360;
    localparam logic [11:0] X_BRANCH     = 12'd3000;
    localparam logic [11:0] X_MIRROR_LO  = 12'd3870;
    localparam logic [11:0] X_MIRROR_HI  = 12'd3800;
    localparam logic [12:0] DEAD_BAND    = 13'd5;

    // reciprocal multipliers: floor(v/q) == (v*m) >> 16 for v below 4096
    localparam int          RECIP_SHIFT  = 16;
    localparam logic [12:0] RECIP_DIV11  = 13'd5958;
    localparam logic [12:0] RECIP_DIV15  = 13'd4370;

    // input item
    typedef struct packed {
        logic        touch_present;
        logic [31:0] sample_word;
    } t_in_item;

    // result item
    typedef struct packed {
        logic                  touch_detected;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } t_out_item;

endpackage

[sv/tpdb_coord.sv]
// ----------------------------------------------------------------------------
// tpdb_coord
// converts one packed raw sample into clamped screen coordinates
// ----------------------------------------------------------------------------
module tpdb_coord (
    input  logic [31:0]                       i_sample_word,
    input  logic [tpdb_pkg::CFG_BITS-1:0]     i_x_limit,
    input  logic [tpdb_pkg::CFG_BITS-1:0]     i_y_limit,
    output logic [tpdb_pkg::COORD_BITS-1:0]   o_new_x,
    output logic [tpdb_pkg::COORD_BITS-1:0]   o_new_y
);

    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [11:0] off_y;
    logic [11:0] mir_x;
    logic [24:0] prod_y;
    logic [24:0] prod_x;
    logic [11:0] div_y;
    logic [11:0] div_x;

    // clamp to limit minus one, a zero limit acting as one
    function automatic logic [11:0] clamp_lim(input logic [11:0] v, input logic [11:0] lim);
        logic [11:0] res;
        res = v;
        if (lim == 12'd0) begin
            res = 12'd0;
        end else if (v >= lim) begin
            res = lim - 12'd1;
        end
        return res;
    endfunction

    // unpack raw fields
    assign raw_x = i_sample_word[31:20];
    assign raw_y = i_sample_word[19:8];

    // y offset with floor at zero
    assign off_y = (raw_y >= tpdb_pkg::Y_OFFSET) ? (raw_y - tpdb_pkg::Y_OFFSET) : 12'd0;

    // x mirror, branch on raw value, floor at zero
    always_comb begin
        if (raw_x <= tpdb_pkg::X_BRANCH) begin
            mir_x = tpdb_pkg::X_MIRROR_LO - raw_x;
        end else if (raw_x <= tpdb_pkg::X_MIRROR_HI) begin
            mir_x = tpdb_pkg::X_MIRROR_HI - raw_x;
        end else begin
            mir_x = 12'd0;
        end
    end

    // constant divides by reciprocal multiply
    assign prod_y = {1'b0, off_y} * {12'd0, tpdb_pkg::RECIP_DIV11};
    assign prod_x = {1'b0, mir_x} * {12'd0, tpdb_pkg::RECIP_DIV15};
    assign div_y  = {3'd0, prod_y[24:tpdb_pkg::RECIP_SHIFT]};
    assign div_x  = {3'd0, prod_x[24:tpdb_pkg::RECIP_SHIFT]};

    // screen limits
    assign o_new_x = clamp_lim(div_x, i_x_limit);
    assign o_new_y = clamp_lim(div_y, i_y_limit);

endmodule

[sv/touch_position_dead_band.sv]
// ----------------------------------------------------------------------------
// touch_position_dead_band
// turns touch samples into screen coordinates held behind a dead band
// ----------------------------------------------------------------------------
// Input channel: one touch sample per transfer (touch flag and packed word,
// raw X in bits 31:20, raw Y in bits 19:8). Output channel: one result per
// sample, carrying the touch flag and the held position.
// Configuration: plain write port, index 0 sets the X limit, index 1 the Y
// limit; the user must write them only while the block is idle, as the block itself does not enforce it.
// A sample passes the input register, then the result register, before output
// valid rises. Throughput: one sample per cycle while the output is not held,
// set by the single pass of conversion and dead-band compare between the two
// registers.
// The held position is updated only on a touch sample whose Manhattan
// distance from it exceeds five pixels; it feeds the next sample directly.
// Reset: limits return to 240 and 320, held position to zero, both stages
// empty.
// Stall: while the output is held the result waits in its register; one more
// sample is still taken into the input register, then input ready drops.
// ----------------------------------------------------------------------------
`include "touch_position_dead_band_macros.svh"

module touch_position_dead_band (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [11:0]          i_cfg_data,
    // sample channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tpdb_pkg::t_in_item   i_in_item,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tpdb_pkg::t_out_item  o_out_item
);

    logic [tpdb_pkg::CFG_BITS-1:0]   r_x_limit;
    logic [tpdb_pkg::CFG_BITS-1:0]   r_y_limit;
    logic                            r_s1_valid;
    tpdb_pkg::t_in_item              r_s1;
    logic                            r_out_valid;
    tpdb_pkg::t_out_item             r_out;
    logic [tpdb_pkg::COORD_BITS-1:0] r_held_x;
    logic [tpdb_pkg::COORD_BITS-1:0] r_held_y;
    logic [tpdb_pkg::COORD_BITS-1:0] n_held_x;
    logic [tpdb_pkg::COORD_BITS-1:0] n_held_y;

    logic                            s1_adv;
    logic                            in_xfer;
    logic [tpdb_pkg::COORD_BITS-1:0] new_x;
    logic [tpdb_pkg::COORD_BITS-1:0] new_y;
    logic [tpdb_pkg::COORD_BITS-1:0] dx;
    logic [tpdb_pkg::COORD_BITS-1:0] dy;
    logic [tpdb_pkg::COORD_BITS:0]   manhattan;
    logic                            take_new;

    // handshake: stage one moves when the result register is free or drained
    assign s1_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit <= tpdb_pkg::X_LIMIT_RST;
            r_y_limit <= tpdb_pkg::Y_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tpdb_pkg::CFG_X_LIMIT: r_x_limit <= i_cfg_data;
                tpdb_pkg::CFG_Y_LIMIT: r_y_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coordinate conversion
    tpdb_coord u_coord (
        .i_sample_word (r_s1.sample_word),
        .i_x_limit     (r_x_limit),
        .i_y_limit     (r_y_limit),
        .o_new_x       (new_x),
        .o_new_y       (new_y)
    );

    // dead band against the held position
    assign dx        = (new_x > r_held_x) ? (new_x - r_held_x) : (r_held_x - new_x);
    assign dy        = (new_y > r_held_y) ? (new_y - r_held_y) : (r_held_y - new_y);
    assign manhattan = {1'b0, dx} + {1'b0, dy};
    assign take_new  = r_s1_valid && s1_adv && r_s1.touch_present
                       && (manhattan > tpdb_pkg::DEAD_BAND);
    assign n_held_x  = take_new ? new_x : r_held_x;
    assign n_held_y  = take_new ? new_y : r_held_y;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (in_xfer) begin
            r_s1 <= i_in_item;
        end
    end

    // held position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
        end else begin
            r_held_x <= n_held_x;
            r_held_y <= n_held_y;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv && r_s1_valid) begin
            r_out.touch_detected <= r_s1.touch_present;
            r_out.pos_x          <= n_held_x;
            r_out.pos_y          <= n_held_y;
        end
    end

    // checks
    `TPDB_ASSERT_NEXT(a_held_only_on_touch, i_clk, i_rst_n, !(s1_adv && r_s1_valid && r_s1.touch_present), $stable(r_held_x) && $stable(r_held_y), "held position moved without a touch transfer")
    `TPDB_ASSERT_NOW(a_out_matches_held, i_clk, i_rst_n, r_out_valid, (r_out.pos_x == r_held_x) && (r_out.pos_y == r_held_y), "pending result differs from held position")
    `TPDB_ASSERT_NEXT(a_stage_moves_to_out, i_clk, i_rst_n, s1_adv && r_s1_valid, r_out_valid, "stage one advanced without filling the result register")

endmodule

[verif/touch_position_dead_band_test.sv]
// ----------------------------------------------------------------------------
// touch_position_dead_band_test
// self-checking bench for the touch position dead band block
// ----------------------------------------------------------------------------
// Sends touch samples over the valid/ready input channel. A local predictor
// converts each accepted sample to screen coordinates, applies the dead band
// to its own held position and queues the expected result. Each result
// transfer is compared field by field with the oldest queued result. Limits
// are rewritten between phases while the block is idle. The sender idles in
// random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module touch_position_dead_band_test;

    localparam int RUN_TIMEOUT    = 1_000_000;
    localparam int DRAIN_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_SAMPLES  = 300;

    // calibration of the conversion
    localparam int Y_CAL_OFFSET   = 360;
    localparam int Y_CAL_SCALE    = 11;
    localparam int X_CAL_SPLIT    = 3000;
    localparam int X_ORIGIN_NEAR  = 3870;
    localparam int X_ORIGIN_FAR   = 3800;
    localparam int X_CAL_SCALE    = 15;
    localparam int MOVE_THRESHOLD = 5;

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            cfg_we     = 1'b0;
    logic                            cfg_index  = tpdb_pkg::CFG_X_LIMIT;
    logic [tpdb_pkg::CFG_BITS-1:0]   cfg_data   = '0;
    logic                            in_valid   = 1'b0;
    logic                            in_ready;
    tpdb_pkg::t_in_item              in_item    = '0;
    logic                            out_valid;
    logic                            out_ready  = 1'b0;
    tpdb_pkg::t_out_item             out_item;

    // predictor state
    logic [tpdb_pkg::CFG_BITS-1:0]   screen_w   = tpdb_pkg::X_LIMIT_RST;
    logic [tpdb_pkg::CFG_BITS-1:0]   screen_h   = tpdb_pkg::Y_LIMIT_RST;
    logic [tpdb_pkg::COORD_BITS-1:0] track_x    = '0;
    logic [tpdb_pkg::COORD_BITS-1:0] track_y    = '0;
    tpdb_pkg::t_out_item             expected_positions[$];

    int mismatch_count = 0;
    int burst_left     = 0;
    int gap_max        = 0;
    int stall_max      = 0;

    touch_position_dead_band dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial begin
        #RUN_TIMEOUT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int span(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // convert one sample and apply the dead band to the held position
    function automatic tpdb_pkg::t_out_item predict_position(tpdb_pkg::t_in_item s);
        int                  raw_x;
        int                  raw_y;
        int                  new_x;
        int                  new_y;
        int                  top_x;
        int                  top_y;
        tpdb_pkg::t_out_item r;
        if (s.touch_present) begin
            raw_x = s.sample_word[31:20];
            raw_y = s.sample_word[19:8];
            // y: offset with floor, then scale
            new_y = (raw_y >= Y_CAL_OFFSET) ? (raw_y - Y_CAL_OFFSET) / Y_CAL_SCALE : 0;
            // x: mirrored about one of two origins, floor at zero
            if (raw_x <= X_CAL_SPLIT)
                new_x = X_ORIGIN_NEAR - raw_x;
            else if (raw_x <= X_ORIGIN_FAR)
                new_x = X_ORIGIN_FAR - raw_x;
            else
                new_x = 0;
            new_x = new_x / X_CAL_SCALE;
            // clamp to the screen, a zero limit behaves as one
            top_x = (screen_w == 0) ? 1 : int'(screen_w);
            top_y = (screen_h == 0) ? 1 : int'(screen_h);
            if (new_x >= top_x)
                new_x = top_x - 1;
            if (new_y >= top_y)
                new_y = top_y - 1;
            if (span(new_x, track_x) + span(new_y, track_y) > MOVE_THRESHOLD) begin
                track_x = tpdb_pkg::COORD_BITS'(new_x);
                track_y = tpdb_pkg::COORD_BITS'(new_y);
            end
        end
        r.touch_detected = s.touch_present;
        r.pos_x          = track_x;
        r.pos_y          = track_y;
        return r;
    endfunction

    function automatic tpdb_pkg::t_in_item make_sample(logic touch, int raw_x, int raw_y,
                                                       logic [7:0] spare);
        tpdb_pkg::t_in_item s;
        s.touch_present = touch;
        s.sample_word   = {12'(raw_x), 12'(raw_y), spare};
        return s;
    endfunction

    // one sample transfer, with a random gap at the start of each burst
    task automatic send_sample(tpdb_pkg::t_in_item s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0) begin
                gap = $urandom_range(0, gap_max);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b1;
        in_item  <= s;
        do @(posedge clk); while (!in_ready);
        expected_positions.push_back(predict_position(s));
        burst_left--;
    endtask

    // drop valid and let every queued result come back
    task automatic wait_idle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_positions.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (expected_positions.size() != 0) begin
            $error("%0d results never arrived", expected_positions.size());
            mismatch_count++;
            expected_positions.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both limits, one per cycle; only called while the block is idle
    task automatic write_limits(logic [tpdb_pkg::CFG_BITS-1:0] w,
                                logic [tpdb_pkg::CFG_BITS-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= tpdb_pkg::CFG_X_LIMIT;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= tpdb_pkg::CFG_Y_LIMIT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        screen_w  = w;
        screen_h  = h;
    endtask

    // conversion corners and the dead band at the reset limits
    task automatic test_reset_limits();
        gap_max   = 0;
        stall_max = 0;
        send_sample(make_sample(1'b0, 1234, 2000, 8'hA5));
        send_sample(make_sample(1'b1, 0, 0, 8'h00));
        send_sample(make_sample(1'b1, 4095, 4095, 8'hFF));
        send_sample(make_sample(1'b1, X_CAL_SPLIT, Y_CAL_OFFSET - 1, 8'h00));
        send_sample(make_sample(1'b1, X_CAL_SPLIT + 1, Y_CAL_OFFSET, 8'h5A));
        send_sample(make_sample(1'b1, X_ORIGIN_FAR, 371, 8'h00));
        send_sample(make_sample(1'b1, X_ORIGIN_FAR + 1, 1000, 8'h00));
        // move of exactly the threshold holds, one more pixel moves
        send_sample(make_sample(1'b1, 1500, 1460, 8'h00));
        send_sample(make_sample(1'b1, 1500, 1515, 8'h00));
        send_sample(make_sample(1'b1, 1500, 1526, 8'h00));
        send_sample(make_sample(1'b1, 1455, 1526, 8'h00));
        // no touch keeps the held position whatever the word
        send_sample(make_sample(1'b0, 4095, 4095, 8'hFF));
        send_sample(make_sample(1'b0, 0, 0, 8'h00));
        wait_idle();
    endtask

    // zero, one and full-range limits
    task automatic test_limit_extremes();
        write_limits('0, '0);
        send_sample(make_sample(1'b1, 0, 0, 8'h00));
        send_sample(make_sample(1'b1, 1500, 4095, 8'h3C));
        wait_idle();
        write_limits(12'd1, 12'd1);
        send_sample(make_sample(1'b1, 100, 3000, 8'h00));
        send_sample(make_sample(1'b1, 4095, 4095, 8'hFF));
        wait_idle();
        write_limits(12'hFFF, 12'hFFF);
        send_sample(make_sample(1'b1, 0, 4095, 8'h00));
        send_sample(make_sample(1'b1, 4095, 0, 8'h00));
        send_sample(make_sample(1'b1, 0, 4095, 8'h81));
        wait_idle();
    endtask

    // random phases: jitter around the last touch, mixed with noise and no-touch samples
    task automatic test_random_traffic();
        int                 last_x;
        int                 last_y;
        int                 pick;
        tpdb_pkg::t_in_item s;
        logic [11:0]        w;
        logic [11:0]        h;
        last_x = 1800;
        last_y = 1800;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    w = tpdb_pkg::X_LIMIT_RST;
                    h = tpdb_pkg::Y_LIMIT_RST;
                end
                1: begin
                    w = 12'hFFF;
                    h = 12'hFFF;
                end
                2: begin
                    w = 12'd1;
                    h = 12'($urandom_range(1, 4095));
                end
                default: begin
                    w = 12'($urandom_range(1, ($urandom_range(0, 1) != 0) ? 300 : 4095));
                    h = 12'($urandom_range(1, ($urandom_range(0, 1) != 0) ? 400 : 4095));
                end
            endcase
            write_limits(w, h);
            gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
            stall_max = (phase % 2 == 0) ? 0 : $urandom_range(1, 8);
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                pick = $urandom_range(0, 99);
                s.sample_word   = $urandom();
                s.touch_present = (pick >= 20);
                if (pick >= 55) begin
                    // small step from the last touch, kept in range
                    last_x = last_x + $urandom_range(0, 120) - 60;
                    last_y = last_y + $urandom_range(0, 120) - 60;
                    last_x = (last_x < 0) ? 0 : (last_x > 4095) ? 4095 : last_x;
                    last_y = (last_y < 0) ? 0 : (last_y > 4095) ? 4095 : last_y;
                    s.sample_word[31:8] = {12'(last_x), 12'(last_y)};
                end else if (s.touch_present) begin
                    last_x = s.sample_word[31:20];
                    last_y = s.sample_word[19:8];
                end
                send_sample(s);
            end
            wait_idle();
        end
        stall_max = 0;
    endtask

    // receiver: ready runs broken by stalls while stalling is enabled
    initial begin
        int run;
        forever begin
            run = $urandom_range(1, 16);
            repeat (run) begin
                @(posedge clk);
                out_ready <= 1'b1;
            end
            if (stall_max > 0) begin
                run = $urandom_range(0, stall_max);
                repeat (run) begin
                    @(posedge clk);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge clk) begin : check_results
        tpdb_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_positions.size() == 0) begin
                $error("unexpected result: touch %0d x %0d y %0d",
                       out_item.touch_detected, out_item.pos_x, out_item.pos_y);
                mismatch_count++;
            end else begin
                want = expected_positions.pop_front();
                if (out_item.touch_detected !== want.touch_detected) begin
                    $error("touch_detected expected %0d actual %0d",
                           want.touch_detected, out_item.touch_detected);
                    mismatch_count++;
                end
                if (out_item.pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d actual %0d", want.pos_x, out_item.pos_x);
                    mismatch_count++;
                end
                if (out_item.pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d actual %0d", want.pos_y, out_item.pos_y);
                    mismatch_count++;
                end
            end
        end
    end

    // reset, tests in turn, verdict
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_limits();
        test_limit_extremes();
        test_random_traffic();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
